>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the converter RTL.
// Each use expands to one labeled concurrent assertion, disabled while the
// active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

>>> rtl/core/rtc_pkg.sv
// ---------------------------------------------------------------------------
// rtc_pkg: shared types and constants of the radix text converter
// Base codes, ASCII constants, the job flag struct and the digit encoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtc_pkg;

    // Input base selector codes
    localparam logic [1:0] ACT_DEC  = 2'd0;
    localparam logic [1:0] ACT_BIN  = 2'd1;
    localparam logic [1:0] ACT_HEX  = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    // Output representation codes
    localparam logic [1:0] REP_DEC = 2'd0;
    localparam logic [1:0] REP_HEX = 2'd1;
    localparam logic [1:0] REP_BIN = 2'd2;

    // ASCII constants
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_ONE       = 8'h31;
    localparam logic [7:0] CHAR_NINE      = 8'h39;
    localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
    localparam logic [7:0] HEX_LETTER_OFS = 8'd39;

    // Entries in the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Per-number flags handed from front to back
    typedef struct packed {
        logic [1:0] action;
        logic       overflow;
        logic       bad;
    } job_flags_t;

    // Digit value 0..15 to lowercase ASCII
    function automatic logic [7:0] digit_to_char(input logic [3:0] d);
        logic [7:0] dx;
        dx = {4'b0000, d};
        if (d < 4'd10) begin
            return CHAR_ZERO + dx;
        end
        return CHAR_ZERO + HEX_LETTER_OFS + dx;
    endfunction

endpackage

>>> rtl/core/rtc_front.sv
// ---------------------------------------------------------------------------
// rtc_front: digit intake and accumulator
// Decodes one ASCII digit per beat, scales and adds it into the running
// value, tracks overflow and bad digits, and posts a job on the last digit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtc_front #(
    parameter int VALUE_BITS = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_action,
    input  logic [7:0]              s_digit_char,
    input  logic                    s_last_digit,
    input  logic                    q_ready,
    output logic                    push_valid,
    output logic [VALUE_BITS-1:0]   push_value,
    output rtc_pkg::job_flags_t     push_flags
);

    localparam int SW = VALUE_BITS + 5;

    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic                  ovf_reg, ovf_next;
    logic                  bad_reg, bad_next;

    logic                  accept;
    logic                  digit_ok;
    logic [3:0]            digit_val;
    logic [SW-1:0]         acc_ext;
    logic [SW-1:0]         scaled;
    logic [SW-1:0]         sum;
    logic                  wrap;
    logic [VALUE_BITS-1:0] new_acc;
    logic                  new_ovf;
    logic                  new_bad;

    assign s_ready = q_ready;
    assign accept  = s_valid & s_ready;

    // Digit decode for the selected base
    always_comb begin
        digit_ok  = 1'b0;
        digit_val = 4'd0;
        case (s_action)
            rtc_pkg::ACT_DEC: begin
                if (s_digit_char inside {[rtc_pkg::CHAR_ZERO:rtc_pkg::CHAR_NINE]}) begin
                    digit_ok  = 1'b1;
                    digit_val = 4'(s_digit_char - rtc_pkg::CHAR_ZERO);
                end
            end
            rtc_pkg::ACT_BIN: begin
                if (s_digit_char inside {rtc_pkg::CHAR_ZERO, rtc_pkg::CHAR_ONE}) begin
                    digit_ok  = 1'b1;
                    digit_val = 4'(s_digit_char - rtc_pkg::CHAR_ZERO);
                end
            end
            rtc_pkg::ACT_HEX: begin
                if (s_digit_char inside {[rtc_pkg::CHAR_ZERO:rtc_pkg::CHAR_NINE]}) begin
                    digit_ok  = 1'b1;
                    digit_val = 4'(s_digit_char - rtc_pkg::CHAR_ZERO);
                end else if (s_digit_char inside
                             {[rtc_pkg::CHAR_LOWER_A:rtc_pkg::CHAR_LOWER_F]}) begin
                    digit_ok  = 1'b1;
                    digit_val = 4'(s_digit_char - rtc_pkg::CHAR_ZERO
                                   - rtc_pkg::HEX_LETTER_OFS);
                end
            end
            default: begin
                digit_ok  = 1'b0;
                digit_val = 4'd0;
            end
        endcase
    end

    // Scale by the radix with shifts and adds; carries above VALUE_BITS flag overflow
    always_comb begin
        acc_ext = SW'(acc_reg);
        case (s_action)
            rtc_pkg::ACT_DEC: scaled = (acc_ext << 3) + (acc_ext << 1);
            rtc_pkg::ACT_BIN: scaled = acc_ext << 1;
            rtc_pkg::ACT_HEX: scaled = acc_ext << 4;
            default:          scaled = acc_ext;
        endcase
        sum     = scaled + SW'(digit_val);
        wrap    = (sum[SW-1:VALUE_BITS] != '0);
        new_acc = sum[VALUE_BITS-1:0];
        new_ovf = ovf_reg | wrap;
        new_bad = bad_reg | ~digit_ok;
    end

    // Job hand-off on the last digit
    assign push_valid        = accept & s_last_digit;
    assign push_value        = new_acc;
    assign push_flags.action = s_action;
    assign push_flags.overflow = new_ovf;
    assign push_flags.bad    = new_bad;

    // Accumulator update
    always_comb begin
        acc_next = acc_reg;
        ovf_next = ovf_reg;
        bad_next = bad_reg;
        if (accept) begin
            if (s_last_digit) begin
                acc_next = '0;
                ovf_next = 1'b0;
                bad_next = 1'b0;
            end else begin
                acc_next = new_acc;
                ovf_next = new_ovf;
                bad_next = new_bad;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            ovf_reg <= 1'b0;
            bad_reg <= 1'b0;
        end else begin
            acc_reg <= acc_next;
            ovf_reg <= ovf_next;
            bad_reg <= bad_next;
        end
    end

    // A finished number leaves a clean accumulator behind
    `ASSERT_NEXT(a_acc_cleared, aclk, aresetn, accept && s_last_digit, acc_reg == '0 && !ovf_reg && !bad_reg)

endmodule

>>> rtl/core/rtc_queue.sv
// ---------------------------------------------------------------------------
// rtc_queue: short job queue
// Holds finished numbers between the intake and the converter so that
// each side stalls on its own.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtc_queue #(
    parameter int DW = 36
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    input  logic [DW-1:0] push_data,
    output logic          push_ready,
    output logic          pop_valid,
    output logic [DW-1:0] pop_data,
    input  logic          pop
);

    localparam int DEPTH = rtc_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop & pop_valid;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The intake never offers a job into a full queue
    `ASSERT_IMPL(a_no_push_full, aclk, aresetn, push_valid, count_reg != CW'(DEPTH))

endmodule

>>> rtl/core/rtc_back.sv
// ---------------------------------------------------------------------------
// rtc_back: digit stream generator
// Converts one queued value into two ASCII representations. Decimal goes
// through an iterative double-dabble pass; all digits then leave a shift
// register most significant first, leading zeros skipped.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtc_back #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  job_valid,
    input  logic [VALUE_BITS-1:0] job_value,
    input  rtc_pkg::job_flags_t   job_flags,
    output logic                  job_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_char,
    output logic [1:0]            m_out_base,
    output logic                  m_end_of_number,
    output logic                  m_overflow,
    output logic                  m_bad_digit,
    output logic                  m_last
);

    // Decimal digits of 2^VALUE_BITS-1 (log10(2) ~ 0.30103), hex digits, register width
    localparam int ND = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int NH = (VALUE_BITS + 3) / 4;
    localparam int W  = 4 * ND;
    localparam int CW = $clog2(VALUE_BITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic [1:0]            rep_reg, rep_next;
    logic                  second_reg, second_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [VALUE_BITS-1:0] bin_sh_reg, bin_sh_next;
    logic [W-1:0]          sr_reg, sr_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    rtc_pkg::job_flags_t   flags_reg, flags_next;

    logic                  m_valid_reg, m_valid_next;
    logic [7:0]            m_char_reg, m_char_next;
    logic [1:0]            m_base_reg, m_base_next;
    logic                  m_end_reg, m_end_next;
    logic                  m_ovf_reg, m_ovf_next;
    logic                  m_bad_reg, m_bad_next;
    logic                  m_last_reg, m_last_next;

    logic                  emit_free;
    logic [3:0]            top_digit;
    logic [W-1:0]          sr_shifted;
    logic [W-1:0]          bcd_adj;
    logic                  start_rep;
    logic [1:0]            start_code;
    logic [VALUE_BITS-1:0] start_val;

    // First and second representation for a given input base
    function automatic logic [1:0] first_rep(input logic [1:0] act);
        return (act == rtc_pkg::ACT_DEC) ? rtc_pkg::REP_HEX : rtc_pkg::REP_DEC;
    endfunction

    function automatic logic [1:0] second_rep(input logic [1:0] act);
        return (act == rtc_pkg::ACT_DEC || act == rtc_pkg::ACT_HEX) ?
               rtc_pkg::REP_BIN : rtc_pkg::REP_HEX;
    endfunction

    assign emit_free = ~m_valid_reg | m_ready;

    // Leading digit and one-digit shift of the output register
    always_comb begin
        if (rep_reg == rtc_pkg::REP_BIN) begin
            top_digit  = {3'b000, sr_reg[W-1]};
            sr_shifted = sr_reg << 1;
        end else begin
            top_digit  = sr_reg[W-1 -: 4];
            sr_shifted = sr_reg << 4;
        end
    end

    // Double-dabble add-3 correction, one per BCD digit
    always_comb begin
        for (int i = 0; i < ND; i++) begin
            bcd_adj[4*i +: 4] = (sr_reg[4*i +: 4] >= 4'd5) ? sr_reg[4*i +: 4] + 4'd3
                                                           : sr_reg[4*i +: 4];
        end
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        rep_next     = rep_reg;
        second_next  = second_reg;
        value_next   = value_reg;
        bin_sh_next  = bin_sh_reg;
        sr_next      = sr_reg;
        cnt_next     = cnt_reg;
        flags_next   = flags_reg;
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_base_next  = m_base_reg;
        m_end_next   = m_end_reg;
        m_ovf_next   = m_ovf_reg;
        m_bad_next   = m_bad_reg;
        m_last_next  = m_last_reg;
        job_pop      = 1'b0;
        start_rep    = 1'b0;
        start_code   = rtc_pkg::REP_DEC;
        start_val    = value_reg;

        // Output slot drains on a taken beat
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    job_pop     = 1'b1;
                    value_next  = job_value;
                    flags_next  = job_flags;
                    second_next = 1'b0;
                    start_rep   = 1'b1;
                    start_code  = first_rep(job_flags.action);
                    start_val   = job_value;
                end
            end
            ST_DABBLE: begin
                sr_next     = {bcd_adj[W-2:0], bin_sh_reg[VALUE_BITS-1]};
                bin_sh_next = bin_sh_reg << 1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    cnt_next   = CW'(ND);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (top_digit == 4'd0 && cnt_reg > CW'(1)) begin
                    sr_next  = sr_shifted;
                    cnt_next = cnt_reg - 1'b1;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = rtc_pkg::digit_to_char(top_digit);
                    m_base_next  = rep_reg;
                    m_end_next   = (cnt_reg == CW'(1));
                    m_last_next  = (cnt_reg == CW'(1)) && second_reg;
                    m_ovf_next   = flags_reg.overflow;
                    m_bad_next   = flags_reg.bad;
                    sr_next      = sr_shifted;
                    cnt_next     = cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1)) begin
                        if (second_reg) begin
                            state_next = ST_IDLE;
                        end else begin
                            second_next = 1'b1;
                            start_rep   = 1'b1;
                            start_code  = second_rep(flags_reg.action);
                            start_val   = value_reg;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Load the shift register for the next representation
        if (start_rep) begin
            rep_next = start_code;
            case (start_code)
                rtc_pkg::REP_DEC: begin
                    sr_next     = '0;
                    bin_sh_next = start_val;
                    cnt_next    = CW'(VALUE_BITS);
                    state_next  = ST_DABBLE;
                end
                rtc_pkg::REP_HEX: begin
                    sr_next    = W'(start_val) << (W - 4 * NH);
                    cnt_next   = CW'(NH);
                    state_next = ST_SKIP;
                end
                default: begin
                    sr_next    = W'(start_val) << (W - VALUE_BITS);
                    cnt_next   = CW'(VALUE_BITS);
                    state_next = ST_SKIP;
                end
            endcase
        end
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            second_reg  <= 1'b0;
            cnt_reg     <= '0;
            rep_reg     <= rtc_pkg::REP_DEC;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            second_reg  <= second_next;
            cnt_reg     <= cnt_next;
            rep_reg     <= rep_next;
        end
        value_reg  <= value_next;
        bin_sh_reg <= bin_sh_next;
        sr_reg     <= sr_next;
        flags_reg  <= flags_next;
        m_char_reg <= m_char_next;
        m_base_reg <= m_base_next;
        m_end_reg  <= m_end_next;
        m_ovf_reg  <= m_ovf_next;
        m_bad_reg  <= m_bad_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_out_char      = m_char_reg;
    assign m_out_base      = m_base_reg;
    assign m_end_of_number = m_end_reg;
    assign m_overflow      = m_ovf_reg;
    assign m_bad_digit     = m_bad_reg;
    assign m_last          = m_last_reg;

    // The run's final beat also closes its representation
    `ASSERT_IMPL(a_last_has_end, aclk, aresetn, m_valid_reg && m_last_reg, m_end_reg)
    // Emitting the final digit returns to idle with that beat on the port
    `ASSERT_NEXT(a_final_to_idle, aclk, aresetn, state_reg == ST_EMIT && emit_free && cnt_reg == CW'(1) && second_reg, state_reg == ST_IDLE && m_valid_reg && m_last_reg)

endmodule

>>> rtl/core/radix_text_converter.sv
// ---------------------------------------------------------------------------
// radix_text_converter: ASCII number to the other two radix representations
// Digits enter most significant first; on the last digit the value leaves
// as two ASCII digit streams (hex lowercase, leading zeros suppressed).
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | beat carries
//  s_      | in        | s_valid / s_ready  | action, digit_char, last_digit
//  m_      | out       | m_valid / m_ready  | out_char, out_base, end_of_number,
//          |           |                    | overflow, bad_digit, last
//
// Digits are taken one per cycle while the two-entry job queue has room.
// Per number the converter pops the job; per representation it runs a
// double-dabble pass (decimal only), skips the leading zeros and then emits
// each digit while m_ready allows.
// Reset is synchronous and active low; no clearing pass is needed.
// Output stalls hold the converter; a full queue holds the digit input.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module radix_text_converter #(
    parameter int VALUE_BITS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic [7:0] s_digit_char,
    input  logic       s_last_digit,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic [1:0] m_out_base,
    output logic       m_end_of_number,
    output logic       m_overflow,
    output logic       m_bad_digit,
    output logic       m_last
);

    localparam int FW = $bits(rtc_pkg::job_flags_t);
    localparam int DW = VALUE_BITS + FW;

    logic                  push_valid;
    logic                  push_ready;
    logic [VALUE_BITS-1:0] push_value;
    rtc_pkg::job_flags_t   push_flags;
    logic                  job_valid;
    logic                  job_pop;
    logic [DW-1:0]         job_data;
    logic [VALUE_BITS-1:0] job_value;
    rtc_pkg::job_flags_t   job_flags;

    // Intake and accumulation
    rtc_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_digit_char (s_digit_char),
        .s_last_digit (s_last_digit),
        .q_ready      (push_ready),
        .push_valid   (push_valid),
        .push_value   (push_value),
        .push_flags   (push_flags)
    );

    // Job queue between the two halves
    rtc_queue #(
        .DW (DW)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  ({push_value, push_flags}),
        .push_ready (push_ready),
        .pop_valid  (job_valid),
        .pop_data   (job_data),
        .pop        (job_pop)
    );

    assign job_value = job_data[DW-1:FW];
    assign job_flags = rtc_pkg::job_flags_t'(job_data[FW-1:0]);

    // Conversion and digit output
    rtc_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .job_valid       (job_valid),
        .job_value       (job_value),
        .job_flags       (job_flags),
        .job_pop         (job_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_char      (m_out_char),
        .m_out_base      (m_out_base),
        .m_end_of_number (m_end_of_number),
        .m_overflow      (m_overflow),
        .m_bad_digit     (m_bad_digit),
        .m_last          (m_last)
    );

endmodule
